[hw/rtl/rsp_pkg.sv]
package rsp_pkg;

    // Payload store size, default for the top level
    localparam int BUFFER_BYTES_DEF = 512;

    // Result queue depth in result groups
    localparam int QUEUE_DEPTH = 4;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 9;
    localparam int LEN_W   = 9;
    localparam int KIND_W  = 2;
    localparam int OFF_W   = 2;
    localparam int DIGIT_W = 5;

    localparam logic [BYTE_W-1:0]  CHAR_START = 8'h24;   // '$'
    localparam logic [BYTE_W-1:0]  CHAR_END   = 8'h23;   // '#'
    localparam logic [BYTE_W-1:0]  CHAR_ESC   = 8'h7D;   // '}'
    localparam logic [BYTE_W-1:0]  CHAR_ACK   = 8'h2B;   // '+'
    localparam logic [BYTE_W-1:0]  CHAR_NAK   = 8'h2D;   // '-'
    localparam logic [BYTE_W-1:0]  CHAR_SEP   = 8'h3A;   // ':'
    localparam logic [BYTE_W-1:0]  ESC_MASK   = 8'h20;
    localparam logic [DIGIT_W-1:0] DIGIT_BAD  = 5'h1F;
    localparam logic [OFF_W-1:0]   OFFSET_ID  = 2'd3;

    typedef enum logic [0:0] {
        OP_RX   = 1'b0,
        OP_READ = 1'b1
    } opcode_e;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR  = 2'd0,
        KIND_READY = 2'd1,
        KIND_READ  = 2'd2
    } kind_e;

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_DATA  = 5'b00010,
        PH_ESC   = 5'b00100,
        PH_SUMHI = 5'b01000,
        PH_SUMLO = 5'b10000
    } phase_e;

    // One group of results caused by one request
    typedef enum logic [1:0] {
        GRP_READ   = 2'd0,
        GRP_NAK    = 2'd1,
        GRP_ACK    = 2'd2,
        GRP_ACK_ID = 2'd3
    } grp_e;

    typedef struct packed {
        grp_e              gtype;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] id0;
        logic [BYTE_W-1:0] id1;
        logic [LEN_W-1:0]  length;
    } grp_t;

    function automatic logic [DIGIT_W-1:0] digit_value(input logic [BYTE_W-1:0] c);
        logic [DIGIT_W-1:0] v;
        if (c >= 8'h61 && c <= 8'h66) begin
            v = DIGIT_W'(c - 8'h57);
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            v = DIGIT_W'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            v = DIGIT_W'(c - 8'h37);
        end
        else begin
            v = DIGIT_BAD;
        end
        return v;
    endfunction

endpackage

[hw/rtl/rsp_if.sv]
interface rsp_in_if;
    import rsp_pkg::*;

    logic               valid;
    logic               ready;
    logic [0:0]         opcode;
    logic [BYTE_W-1:0]  rx_byte;
    logic [INDEX_W-1:0] read_index;

    modport source (output valid, output opcode, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input opcode, input rx_byte, input read_index,
                    output ready);
endinterface

interface rsp_out_if;
    import rsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [OFF_W-1:0]  payload_offset;
    logic [LEN_W-1:0]  payload_length;
    logic              last;

    modport source (output valid, output kind, output data_byte, output payload_offset,
                    output payload_length, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input payload_offset,
                    input payload_length, input last, output ready);
endinterface

[hw/rtl/rsp_frame_ctl.sv]
module rsp_frame_ctl #(
    parameter int BUFFER_BYTES = rsp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [0:0]                  opcode,
    input  logic [rsp_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [rsp_pkg::INDEX_W-1:0] read_index,
    output logic                        grp_valid,
    output rsp_pkg::grp_t               grp
);
    import rsp_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam logic [AW-1:0] FULL_AT = AW'(BUFFER_BYTES - 1);

    logic [BYTE_W-1:0] store_mem [BUFFER_BYTES];

    phase_e             phase_reg, phase_next;
    logic [BYTE_W-1:0]  sum_reg, sum_next;
    logic [AW-1:0]      count_reg, count_next;
    logic [DIGIT_W-1:0] high_reg, high_next;
    logic [BYTE_W-1:0]  id0_reg, id1_reg, id2_reg;

    logic               wr_en;
    logic [BYTE_W-1:0]  wr_byte;
    logic [AW-1:0]      count_inc;
    logic [DIGIT_W-1:0] lo_digit;
    logic [BYTE_W-1:0]  hi_part, lo_part, got_sum;
    logic               is_rx, is_read, in_range;

    logic               grp_valid_reg, grp_valid_next;
    grp_t               grp_reg, grp_next;
    logic               in_range_reg;
    logic [BYTE_W-1:0]  rd_data_reg;

    assign is_rx     = fire && (opcode == OP_RX);
    assign is_read   = fire && (opcode == OP_READ);
    assign in_range  = CW'(read_index) < CW'(BUFFER_BYTES);
    assign count_inc = count_reg + AW'(1);
    assign lo_digit  = digit_value(rx_byte);
    assign hi_part   = (high_reg == DIGIT_BAD) ? 8'hF0 : {high_reg[3:0], 4'h0};
    assign lo_part   = (lo_digit == DIGIT_BAD) ? 8'hFF : {3'b000, lo_digit};
    assign got_sum   = hi_part + lo_part;

    always_comb
    begin
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        high_next      = high_reg;
        wr_en          = 1'b0;
        wr_byte        = rx_byte;
        grp_valid_next = is_read;
        grp_next       = '{gtype: GRP_READ, data: '0, id0: id0_reg, id1: id1_reg,
                           length: '0};
        if (is_rx)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == CHAR_START)
                    begin
                        phase_next = PH_DATA;
                        sum_next   = '0;
                        count_next = '0;
                    end
                end
                PH_DATA:
                begin
                    if (rx_byte == CHAR_START)
                    begin
                        sum_next   = '0;
                        count_next = '0;
                    end
                    else if (rx_byte == CHAR_END)
                    begin
                        phase_next = PH_SUMHI;
                    end
                    else
                    begin
                        sum_next = sum_reg + rx_byte;
                        if (rx_byte == CHAR_ESC)
                        begin
                            phase_next = PH_ESC;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                        end
                    end
                end
                PH_ESC:
                begin
                    sum_next = sum_reg + rx_byte;
                    wr_byte  = rx_byte ^ ESC_MASK;
                    wr_en    = 1'b1;
                end
                PH_SUMHI:
                begin
                    high_next  = lo_digit;
                    phase_next = PH_SUMLO;
                end
                PH_SUMLO:
                begin
                    phase_next     = PH_HUNT;
                    grp_valid_next = 1'b1;
                    if (got_sum != sum_reg)
                    begin
                        grp_next.gtype = GRP_NAK;
                    end
                    else if (count_reg >= AW'(3) && id2_reg == CHAR_SEP)
                    begin
                        grp_next.gtype  = GRP_ACK_ID;
                        grp_next.length = LEN_W'(count_reg - AW'(3));
                    end
                    else
                    begin
                        grp_next.gtype  = GRP_ACK;
                        grp_next.length = LEN_W'(count_reg);
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
            // Drop the packet once the store is one short of full
            if (wr_en)
            begin
                if (count_inc == FULL_AT)
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                    sum_next   = '0;
                end
                else
                begin
                    phase_next = PH_DATA;
                    count_next = count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            sum_reg       <= '0;
            count_reg     <= '0;
            high_reg      <= '0;
            grp_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            high_reg      <= high_next;
            grp_valid_reg <= grp_valid_next;
        end
    end

    // Payload store and the id shadow of its first three bytes
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[count_reg] <= wr_byte;
            if (count_reg == AW'(0))
            begin
                id0_reg <= wr_byte;
            end
            if (count_reg == AW'(1))
            begin
                id1_reg <= wr_byte;
            end
            if (count_reg == AW'(2))
            begin
                id2_reg <= wr_byte;
            end
        end
        if (is_read)
        begin
            rd_data_reg  <= store_mem[AW'(read_index)];
            in_range_reg <= in_range;
        end
        grp_reg <= grp_next;
    end

    always_comb
    begin
        grp = grp_reg;
        if (grp_reg.gtype == GRP_READ)
        begin
            grp.data = in_range_reg ? rd_data_reg : '0;
        end
    end

    assign grp_valid = grp_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < FULL_AT)
        else $error("fill count reached the drop limit");

    a_check_result: assert property (@(posedge clk) disable iff (!rst_n)
        (is_rx && phase_reg == PH_SUMLO) |=> (grp_valid && grp.gtype != GRP_READ))
        else $error("checksum byte gave no reply group");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        is_read |=> (grp_valid && grp.gtype == GRP_READ))
        else $error("read request gave no read group");

endmodule

[hw/rtl/rsp_result_queue.sv]
module rsp_result_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  rsp_pkg::grp_t              push_grp,
    output logic                       room,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rsp_pkg::KIND_W-1:0] out_kind,
    output logic [rsp_pkg::BYTE_W-1:0] out_data,
    output logic [rsp_pkg::OFF_W-1:0]  out_offset,
    output logic [rsp_pkg::LEN_W-1:0]  out_length,
    output logic                       out_last
);
    import rsp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    grp_t          qbuf_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic [1:0]    beat_reg, beat_next;
    grp_t          head;
    logic          pop, fire;

    assign head      = qbuf_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign fire      = out_valid && out_ready;
    assign pop       = fire && out_last;

    // One slot is held back for the group that may be in flight
    assign room = (count_reg + NW'(push)) < NW'(QUEUE_DEPTH);

    always_comb
    begin
        out_kind   = KIND_CHAR;
        out_data   = '0;
        out_offset = '0;
        out_length = '0;
        out_last   = 1'b1;
        case (head.gtype)
            GRP_READ:
            begin
                out_kind = KIND_READ;
                out_data = head.data;
            end
            GRP_NAK:
            begin
                out_data = CHAR_NAK;
            end
            GRP_ACK:
            begin
                if (beat_reg == 2'd0)
                begin
                    out_data = CHAR_ACK;
                    out_last = 1'b0;
                end
                else
                begin
                    out_kind   = KIND_READY;
                    out_length = head.length;
                end
            end
            default:
            begin
                out_last = 1'b0;
                case (beat_reg)
                    2'd0: out_data = CHAR_ACK;
                    2'd1: out_data = head.id0;
                    2'd2: out_data = head.id1;
                    default:
                    begin
                        out_kind   = KIND_READY;
                        out_offset = OFFSET_ID;
                        out_length = head.length;
                        out_last   = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        beat_next   = beat_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            beat_next   = '0;
        end
        else if (fire)
        begin
            beat_next = beat_reg + 2'd1;
        end
        count_next = count_reg + NW'(push) - NW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            beat_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            beat_reg   <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qbuf_reg[wr_ptr_reg] <= push_grp;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < NW'(QUEUE_DEPTH)))
        else $error("result queue overflow");

    a_beat_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (beat_reg == 2'd0))
        else $error("beat counter not cleared after group");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable({out_kind, out_data, out_offset, out_length, out_last})))
        else $error("waiting result changed before it was taken");

endmodule

[hw/rtl/rsp_packet_receiver.sv]
// Channel   Dir  Payload                                             Accept
// inbound   in   opcode, rx_byte, read_index                         valid && ready
// outbound  out  kind, data_byte, payload_offset, payload_length,    valid && ready
//                last
//
// One request per cycle is taken while the result queue has room. A received
// byte updates the frame state in the cycle it is taken; a read returns its
// byte via the registered store read and the queue. A checksum byte queues
// a reply group of one, two or four results, sent one per cycle while outbound
// is ready. Reset clears the frame state and the queue; the payload store is
// not cleared. A stalled outbound drops inbound ready with one of four slots free.
module rsp_packet_receiver #(
    parameter int BUFFER_BYTES = rsp_pkg::BUFFER_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rsp_in_if.sink    inbound,
    rsp_out_if.source outbound
);
    import rsp_pkg::*;

    logic in_fire;
    logic grp_valid;
    grp_t grp;
    logic room;

    // Hold ready low while the queue has no slot beyond the group in flight
    assign inbound.ready = room;
    assign in_fire       = inbound.valid && inbound.ready;

    // Parse framing, keep the checksum, and write or read the payload store
    rsp_frame_ctl #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .opcode     (inbound.opcode),
        .rx_byte    (inbound.rx_byte),
        .read_index (inbound.read_index),
        .grp_valid  (grp_valid),
        .grp        (grp)
    );

    // Queue reply groups and advance them out one result at a time
    rsp_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (grp_valid),
        .push_grp   (grp),
        .room       (room),
        .out_valid  (outbound.valid),
        .out_ready  (outbound.ready),
        .out_kind   (outbound.kind),
        .out_data   (outbound.data_byte),
        .out_offset (outbound.payload_offset),
        .out_length (outbound.payload_length),
        .out_last   (outbound.last)
    );

endmodule
